FILE: rtl/c8ie_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the CHIP-8 instruction execute block.
// No dependencies; the execute module and the top level import this package.
package c8ie_pkg;

    // Return stack sizing.
    localparam int STACK_DEPTH = 16;
    localparam int STK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STK_LVL_W   = $clog2(STACK_DEPTH + 1);

    // Program counter value after reset.
    localparam logic [11:0] START_ADDR_RESET = 12'h200;

    // Index of the flag register.
    localparam logic [3:0] VF_IDX = 4'hF;

    // Major opcodes (top nibble).
    localparam logic [3:0] OP_SYS     = 4'h0;
    localparam logic [3:0] OP_JP      = 4'h1;
    localparam logic [3:0] OP_CALL    = 4'h2;
    localparam logic [3:0] OP_SE_IMM  = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4;
    localparam logic [3:0] OP_SE_REG  = 4'h5;
    localparam logic [3:0] OP_LD_IMM  = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7;
    localparam logic [3:0] OP_ALU     = 4'h8;
    localparam logic [3:0] OP_SNE_REG = 4'h9;
    localparam logic [3:0] OP_LD_I    = 4'hA;
    localparam logic [3:0] OP_JP_V0   = 4'hB;
    localparam logic [3:0] OP_RND     = 4'hC;
    localparam logic [3:0] OP_DRW     = 4'hD;
    localparam logic [3:0] OP_SKP     = 4'hE;
    localparam logic [3:0] OP_MISC    = 4'hF;

    // Full instruction words of the system group.
    localparam logic [15:0] INS_CLS = 16'h00E0;
    localparam logic [15:0] INS_RET = 16'h00EE;

    // Sub-codes of the register ALU group (low nibble).
    localparam logic [3:0] ALU_LD   = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Low-byte codes of the key-skip and miscellaneous groups.
    localparam logic [7:0] EX_SKP      = 8'h9E;
    localparam logic [7:0] EX_SKNP     = 8'hA1;
    localparam logic [7:0] FX_LD_VDT   = 8'h07;
    localparam logic [7:0] FX_LD_KEY   = 8'h0A;
    localparam logic [7:0] FX_LD_DT    = 8'h15;
    localparam logic [7:0] FX_LD_ST    = 8'h18;
    localparam logic [7:0] FX_ADD_I    = 8'h1E;
    localparam logic [7:0] FX_LD_FONT  = 8'h29;
    localparam logic [7:0] FX_BCD      = 8'h33;
    localparam logic [7:0] FX_STORE    = 8'h55;
    localparam logic [7:0] FX_LOAD     = 8'h65;

    // Status codes reported with each result.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_UNSUPPORTED = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_UNDERFLOW   = 3'd4
    } status_t;

    // Outcome of executing one instruction.
    typedef struct packed {
        logic [11:0] next_pc;
        logic        clr;
        logic        wr;
        logic [3:0]  wr_idx;
        logic [7:0]  wr_val;
        logic        flg;
        logic        fval;
        logic        push;
        logic [11:0] push_pc;
        logic        pop;
        status_t     status;
    } exec_t;

endpackage

FILE: rtl/c8ie_intf.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instructions in and results out.
// Depends on nothing; the top level uses both.
interface c8ie_instr_if;
    logic        valid;
    logic        ready;
    logic [15:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface c8ie_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] next_pc;
    logic        clear_screen;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [7:0]  reg_value;
    logic        flag_written;
    logic [2:0]  status;

    modport source (output valid, output next_pc, output clear_screen, output reg_written,
                    output reg_index, output reg_value, output flag_written,
                    output status, input ready);
    modport sink   (input valid, input next_pc, input clear_screen, input reg_written,
                    input reg_index, input reg_value, input flag_written,
                    input status, output ready);
endinterface

FILE: rtl/c8ie_exec.sv
`timescale 1ns / 1ps
// Combinational decode and execute of one CHIP-8 instruction.
// Depends on c8ie_pkg for opcodes, status codes and the exec_t result.
module c8ie_exec
    import c8ie_pkg::*;
(
    input  logic [15:0]          instruction,
    input  logic [7:0]           vx,
    input  logic [7:0]           vy,
    input  logic [11:0]          pc,
    input  logic [STK_LVL_W-1:0] level,
    input  logic [11:0]          stack_top,
    output exec_t                result
);

    logic [3:0]  op;
    logic [3:0]  x;
    logic [3:0]  n;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [11:0] pc_adv;
    logic [11:0] pc_skip;
    logic [8:0]  sum;

    assign op      = instruction[15:12];
    assign x       = instruction[11:8];
    assign n       = instruction[3:0];
    assign nn      = instruction[7:0];
    assign nnn     = instruction[11:0];
    assign pc_adv  = pc + 12'd2;
    assign pc_skip = pc + 12'd4;
    assign sum     = {1'b0, vx} + {1'b0, vy};

    // Main decoder: every instruction advances the PC by two unless it says otherwise.
    always_comb
    begin
        result         = '0;
        result.next_pc = pc_adv;
        result.wr_idx  = x;
        result.push_pc = pc_adv;
        result.status  = ST_OK;

        unique case (op) inside
            OP_SYS:
            begin
                if (instruction == INS_CLS)
                begin
                    result.clr = 1'b1;
                end
                else if (instruction == INS_RET)
                begin
                    if (level == '0)
                    begin
                        result.status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        result.pop     = 1'b1;
                        result.next_pc = stack_top;
                    end
                end
                else
                begin
                    result.status = ST_UNSUPPORTED;
                end
            end
            OP_JP:
            begin
                result.next_pc = nnn;
            end
            OP_CALL:
            begin
                if (level >= STK_LVL_W'(STACK_DEPTH))
                begin
                    result.status = ST_OVERFLOW;
                end
                else
                begin
                    result.push    = 1'b1;
                    result.next_pc = nnn;
                end
            end
            OP_SE_IMM:
            begin
                if (vx == nn)
                begin
                    result.next_pc = pc_skip;
                end
            end
            OP_SNE_IMM:
            begin
                if (vx != nn)
                begin
                    result.next_pc = pc_skip;
                end
            end
            OP_SE_REG:
            begin
                if (n != 4'h0)
                begin
                    result.status = ST_INVALID;
                end
                else if (vx == vy)
                begin
                    result.next_pc = pc_skip;
                end
            end
            OP_LD_IMM:
            begin
                result.wr     = 1'b1;
                result.wr_val = nn;
            end
            OP_ADD_IMM:
            begin
                result.wr     = 1'b1;
                result.wr_val = vx + nn;
            end
            OP_ALU:
            begin
                unique case (n) inside
                    ALU_LD:
                    begin
                        result.wr     = 1'b1;
                        result.wr_val = vy;
                    end
                    ALU_OR:
                    begin
                        result.wr     = 1'b1;
                        result.wr_val = vx | vy;
                    end
                    ALU_AND:
                    begin
                        result.wr     = 1'b1;
                        result.wr_val = vx & vy;
                    end
                    ALU_XOR:
                    begin
                        result.wr     = 1'b1;
                        result.wr_val = vx ^ vy;
                    end
                    ALU_ADD:
                    begin
                        result.wr     = 1'b1;
                        result.wr_val = sum[7:0];
                        result.flg    = 1'b1;
                        result.fval   = sum[8];
                    end
                    ALU_SUB:
                    begin
                        result.wr     = 1'b1;
                        result.wr_val = vx - vy;
                        result.flg    = 1'b1;
                        result.fval   = (vx >= vy);
                    end
                    ALU_SHR, ALU_SUBN, ALU_SHL:
                    begin
                        result.status = ST_UNSUPPORTED;
                    end
                    default:
                    begin
                        result.status = ST_INVALID;
                    end
                endcase
            end
            OP_SNE_REG:
            begin
                result.status = (n == 4'h0) ? ST_UNSUPPORTED : ST_INVALID;
            end
            OP_LD_I, OP_JP_V0, OP_RND, OP_DRW:
            begin
                result.status = ST_UNSUPPORTED;
            end
            OP_SKP:
            begin
                result.status = (nn == EX_SKP || nn == EX_SKNP) ? ST_UNSUPPORTED : ST_INVALID;
            end
            OP_MISC:
            begin
                unique case (nn) inside
                    FX_LD_VDT, FX_LD_KEY, FX_LD_DT, FX_LD_ST, FX_ADD_I,
                    FX_LD_FONT, FX_BCD, FX_STORE, FX_LOAD:
                    begin
                        result.status = ST_UNSUPPORTED;
                    end
                    default:
                    begin
                        result.status = ST_INVALID;
                    end
                endcase
            end
            default:
            begin
                result.status = ST_INVALID;
            end
        endcase
    end

endmodule

FILE: rtl/chip8_instruction_execute_top.sv
`timescale 1ns / 1ps
// CHIP-8 instruction execute block: PC, V registers, return stack and result output.
// A result passes the input stage register, then the output register. Throughput: one
// instruction per cycle unless result_ch.ready stalls the output; the V register file
// read port and the single execute pass set that figure. Reset (rst_n low, asynchronous)
// loads PC 0x200, zeroes V0..VF and the stack level, empties the input and output stages.
module chip8_instruction_execute_top
    import c8ie_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [11:0]          cfg_wdata,
    c8ie_instr_if.sink           instr_ch,
    c8ie_result_if.source        result_ch
);

    // Pipeline control and state.
    logic                 s1_valid_reg;
    logic [15:0]          s1_instr_reg;
    logic                 out_valid_reg;
    logic [11:0]          pc_reg;
    logic [STK_LVL_W-1:0] level_reg;
    logic [7:0]           vf_reg;
    logic [11:0]          stack_reg [STACK_DEPTH];

    // V0..VE file with registered reads, valid bits standing in for the zero reset.
    logic [7:0]           vmem [16];
    logic [15:0]          vmem_valid_reg;
    logic [7:0]           rd_x_reg;
    logic [7:0]           rd_y_reg;
    logic                 rd_x_ok_reg;
    logic                 rd_y_ok_reg;
    logic                 fwd_x_reg;
    logic                 fwd_y_reg;
    logic [7:0]           fwd_val_reg;

    // Output payload registers.
    logic [11:0]          out_pc_reg;
    logic                 out_clr_reg;
    logic                 out_wr_reg;
    logic [3:0]           out_idx_reg;
    logic [7:0]           out_val_reg;
    logic                 out_flg_reg;
    status_t              out_status_reg;

    logic                 in_fire;
    logic                 exe_fire;
    logic [3:0]           x_in;
    logic [3:0]           y_in;
    logic [3:0]           s1_x;
    logic [3:0]           s1_y;
    logic [7:0]           vx;
    logic [7:0]           vy;
    logic [STK_LVL_W-1:0] level_dec;
    logic [11:0]          stack_top;
    logic                 mem_we;
    exec_t                ex;

    // Handshake: the execute stage moves on whenever the output register is free or emptying.
    assign exe_fire       = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign instr_ch.ready = !s1_valid_reg || exe_fire;
    assign in_fire        = instr_ch.valid && instr_ch.ready;

    assign x_in = instr_ch.instruction[11:8];
    assign y_in = instr_ch.instruction[7:4];
    assign s1_x = s1_instr_reg[11:8];
    assign s1_y = s1_instr_reg[7:4];

    // Operand selection: VF lives in its own register, others come from the file or bypass.
    always_comb
    begin
        if (s1_x == VF_IDX)
            vx = vf_reg;
        else if (fwd_x_reg)
            vx = fwd_val_reg;
        else
            vx = rd_x_ok_reg ? rd_x_reg : 8'h00;

        if (s1_y == VF_IDX)
            vy = vf_reg;
        else if (fwd_y_reg)
            vy = fwd_val_reg;
        else
            vy = rd_y_ok_reg ? rd_y_reg : 8'h00;
    end

    // Top of the return stack.
    assign level_dec = level_reg - STK_LVL_W'(1);
    assign stack_top = stack_reg[level_dec[STK_IDX_W-1:0]];

    c8ie_exec u_exec (
        .instruction (s1_instr_reg),
        .vx          (vx),
        .vy          (vy),
        .pc          (pc_reg),
        .level       (level_reg),
        .stack_top   (stack_top),
        .result      (ex)
    );

    assign mem_we = exe_fire && ex.wr && (ex.wr_idx != VF_IDX);

    // Input stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (instr_ch.ready)
        begin
            s1_valid_reg <= instr_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_instr_reg <= instr_ch.instruction;
        end
    end

    // Register file write port and read ports, with bypass of the write in flight.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vmem[ex.wr_idx] <= ex.wr_val;
        end
        if (in_fire)
        begin
            rd_x_reg    <= vmem[x_in];
            rd_y_reg    <= vmem[y_in];
            fwd_x_reg   <= mem_we && (ex.wr_idx == x_in);
            fwd_y_reg   <= mem_we && (ex.wr_idx == y_in);
            fwd_val_reg <= ex.wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vmem_valid_reg <= '0;
            rd_x_ok_reg    <= 1'b0;
            rd_y_ok_reg    <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vmem_valid_reg[ex.wr_idx] <= 1'b1;
            end
            if (in_fire)
            begin
                rd_x_ok_reg <= vmem_valid_reg[x_in];
                rd_y_ok_reg <= vmem_valid_reg[y_in];
            end
        end
    end

    // Architectural state: PC, flag register and stack level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= START_ADDR_RESET;
            vf_reg    <= 8'h00;
            level_reg <= '0;
        end
        else if (cfg_we)
        begin
            pc_reg <= cfg_wdata;
        end
        else if (exe_fire)
        begin
            pc_reg <= ex.next_pc;
            // The flag takes priority over the result, so it wins when x is F.
            if (ex.flg)
                vf_reg <= {7'b0, ex.fval};
            else if (ex.wr && (ex.wr_idx == VF_IDX))
                vf_reg <= ex.wr_val;
            if (ex.push)
                level_reg <= level_reg + STK_LVL_W'(1);
            else if (ex.pop)
                level_reg <= level_dec;
        end
    end

    // Return stack entries.
    always_ff @(posedge clk)
    begin
        if (exe_fire && ex.push)
        begin
            stack_reg[level_reg[STK_IDX_W-1:0]] <= ex.push_pc;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exe_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exe_fire)
        begin
            out_pc_reg     <= ex.next_pc;
            out_clr_reg    <= ex.clr;
            out_wr_reg     <= ex.wr;
            out_idx_reg    <= ex.wr ? ex.wr_idx : 4'h0;
            out_val_reg    <= ex.wr ? ex.wr_val : 8'h00;
            out_flg_reg    <= ex.flg;
            out_status_reg <= ex.status;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.next_pc      = out_pc_reg;
    assign result_ch.clear_screen = out_clr_reg;
    assign result_ch.reg_written  = out_wr_reg;
    assign result_ch.reg_index    = out_idx_reg;
    assign result_ch.reg_value    = out_val_reg;
    assign result_ch.flag_written = out_flg_reg;
    assign result_ch.status       = out_status_reg;

`ifndef SYNTHESIS
    // The stack level never passes the stack depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= STK_LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    // A return pops only a non-empty stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        exe_fire && ex.pop |-> level_reg != '0)
        else $error("pop from empty stack");

    // A call that pushes with cfg_we low raises the level by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        exe_fire && ex.push && !cfg_we |=> level_reg == $past(level_reg) + STK_LVL_W'(1))
        else $error("stack level not raised by push");

    // An executed instruction always leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        exe_fire |=> out_valid_reg)
        else $error("result lost");
`endif

endmodule
